// ===== sv/config_language_tokenizer_macros.svh =====
// Assertion helpers for the tokenizer
`ifndef CONFIG_LANGUAGE_TOKENIZER_MACROS_SVH
`define CONFIG_LANGUAGE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/clt_pkg.sv =====
package clt_pkg;

  localparam int PosW = 24;
  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [1:0] EV_TEXT    = 2'd0;
  localparam logic [1:0] EV_END     = 2'd1;
  localparam logic [1:0] EV_ABANDON = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [4:0] KIND_IDENT    = 5'd0;
  localparam logic [4:0] KIND_INT      = 5'd10;
  localparam logic [4:0] KIND_NUMBER   = 5'd11;
  localparam logic [4:0] KIND_STRING   = 5'd12;
  localparam logic [4:0] KIND_ASSIGN   = 5'd13;
  localparam logic [4:0] KIND_LBRACE   = 5'd14;
  localparam logic [4:0] KIND_RBRACE   = 5'd15;
  localparam logic [4:0] KIND_LBRACKET = 5'd16;
  localparam logic [4:0] KIND_RBRACKET = 5'd17;
  localparam logic [4:0] KIND_COMMA    = 5'd18;
  localparam logic [4:0] KIND_EOF      = 5'd19;

  localparam logic [1:0] ERR_EXTRA_POINT  = 2'd0;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
  localparam logic [1:0] ERR_ESCAPE       = 2'd2;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd3;

  localparam int NumKeywords = 9;
  localparam int KeywordMax  = 10;

  // left-justified, first character in the top byte
  localparam logic [KeywordMax*8-1:0] KW_TEXT [NumKeywords] = '{
    {"game", 48'h0}, {"world", 40'h0}, {"terrain", 24'h0}, "vegetation",
    {"building", 16'h0}, {"vehicle", 24'h0}, "procedural", {"true", 48'h0},
    {"false", 40'h0}
  };
  localparam logic [4:0] KW_LEN [NumKeywords] = '{
    5'd4, 5'd5, 5'd7, 5'd10, 5'd8, 5'd7, 5'd10, 5'd4, 5'd5
  };

  localparam int EventsPerBeat = 4;
  localparam int QueueDepth    = 4;
  localparam int QPtrW         = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } clt_item_t;

  typedef struct packed {
    logic [1:0]      event_type;
    logic [4:0]      token_kind;
    logic [1:0]      error_code;
    logic [7:0]      text_byte;
    logic [PosW-1:0] position_offset;
    logic [PosW-1:0] position_line;
    logic [PosW-1:0] position_column;
    logic            last_of_run;
  } clt_result_t;

  typedef struct packed {
    logic [1:0]      event_type;
    logic [4:0]      token_kind;
    logic [1:0]      error_code;
    logic [7:0]      text_byte;
    logic [PosW-1:0] position_offset;
    logic [PosW-1:0] position_line;
    logic [PosW-1:0] position_column;
  } clt_event_t;

  typedef struct packed {
    logic [2:0]                         count;
    clt_event_t [EventsPerBeat-1:0]     ev;
  } clt_bundle_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QPtrW:0] count;
  } clt_qstat_t;

endpackage

// ===== sv/clt_front.sv =====
module clt_front #(
  parameter longint unsigned MAX_SOURCE_BYTES = 64'd16777216,
  parameter int              KEYWORD_CHARS    = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  clt_pkg::clt_item_t item,
  output clt_pkg::clt_bundle_t bundle
);
  import clt_pkg::*;

  localparam int CW = $clog2(MAX_SOURCE_BYTES + 64'd1);
  localparam int LW = $clog2(KEYWORD_CHARS + 2);
  localparam int IW = $clog2(KEYWORD_CHARS);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_MINUS   = 4'd3;
  localparam logic [3:0] M_WORD    = 4'd4;
  localparam logic [3:0] M_INT     = 4'd5;
  localparam logic [3:0] M_FRAC    = 4'd6;
  localparam logic [3:0] M_BADNUM  = 4'd7;
  localparam logic [3:0] M_STR     = 4'd8;
  localparam logic [3:0] M_ESC     = 4'd9;

  logic [3:0]      mode, mode_next;
  logic [7:0]      word_store [KEYWORD_CHARS];
  logic [LW-1:0]   word_length, word_length_next;
  logic            decimal_seen, decimal_seen_next;
  logic [PosW-1:0] byte_offset, byte_offset_next;
  logic [PosW-1:0] line_number, line_number_next;
  logic [PosW-1:0] column_number, column_number_next;
  logic [PosW-1:0] start_offset, start_offset_next;
  logic [PosW-1:0] start_line, start_line_next;
  logic [PosW-1:0] start_column, start_column_next;
  logic [CW-1:0]   bytes_taken, bytes_taken_next;

  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic [4:0]      word_kind;
  logic [7:0]      c;
  logic            fresh;
  logic [2:0]      n;

  function automatic clt_event_t make_ev(logic [1:0] t, logic [4:0] k, logic [1:0] e,
                                         logic [7:0] b, logic [PosW-1:0] o,
                                         logic [PosW-1:0] l, logic [PosW-1:0] col);
    clt_event_t r;
    r.event_type      = t;
    r.token_kind      = k;
    r.error_code      = e;
    r.text_byte       = b;
    r.position_offset = o;
    r.position_line   = l;
    r.position_column = col;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] x);
    return x == " " || (x >= 8'd9 && x <= 8'd13);
  endfunction

  assign c = item.source_byte;

  always_comb begin
    logic hit;
    word_kind = KIND_IDENT;
    for (int k = 0; k < NumKeywords; k++) begin
      hit = (word_length == LW'(KW_LEN[k]));
      for (int i = 0; i < KeywordMax; i++) begin
        if (i < int'(KW_LEN[k]) && word_store[i] != KW_TEXT[k][(KeywordMax-1-i)*8 +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit && word_kind == KIND_IDENT) begin
        word_kind = 5'(k + 1);
      end
    end
  end

  always_comb begin
    mode_next          = mode;
    word_length_next   = word_length;
    decimal_seen_next  = decimal_seen;
    byte_offset_next   = byte_offset;
    line_number_next   = line_number;
    column_number_next = column_number;
    start_offset_next  = start_offset;
    start_line_next    = start_line;
    start_column_next  = start_column;
    bytes_taken_next   = bytes_taken;
    wr_en              = 1'b0;
    wr_idx             = word_length[IW-1:0];
    fresh              = 1'b0;
    n                  = 3'd0;
    bundle             = '0;

    if (item.end_of_source) begin
      unique case (mode) inside
        M_WORD: begin
          bundle.ev[n[1:0]] = make_ev(EV_END, word_kind, ERR_EXTRA_POINT, 8'd0,
                                      start_offset, start_line, start_column);
          n = n + 3'd1;
        end
        M_INT, M_FRAC, M_BADNUM: begin
          bundle.ev[n[1:0]] = make_ev(EV_END, decimal_seen ? KIND_NUMBER : KIND_INT,
                                      ERR_EXTRA_POINT, 8'd0,
                                      start_offset, start_line, start_column);
          n = n + 3'd1;
        end
        M_SLASH, M_MINUS: begin
          bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_UNEXPECTED, 8'd0,
                                      start_offset, start_line, start_column);
          n = n + 3'd1;
        end
        M_STR, M_ESC: begin
          bundle.ev[n[1:0]] = make_ev(EV_ABANDON, KIND_STRING, ERR_EXTRA_POINT, 8'd0,
                                      start_offset, start_line, start_column);
          n = n + 3'd1;
        end
        default: ;
      endcase
      bundle.ev[n[1:0]] = make_ev(EV_END, KIND_EOF, ERR_EXTRA_POINT, 8'd0,
                                  byte_offset, line_number, column_number);
      n = n + 3'd1;
      mode_next          = M_IDLE;
      word_length_next   = '0;
      decimal_seen_next  = 1'b0;
      byte_offset_next   = '0;
      line_number_next   = PosW'(1);
      column_number_next = PosW'(1);
      start_offset_next  = '0;
      start_line_next    = PosW'(1);
      start_column_next  = PosW'(1);
      bytes_taken_next   = '0;
    end else if (bytes_taken < CW'(MAX_SOURCE_BYTES)) begin
      bytes_taken_next = bytes_taken + CW'(1);
      unique case (mode)
        M_IDLE: fresh = 1'b1;
        M_SLASH: begin
          if (c == "/") begin
            mode_next = M_COMMENT;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_UNEXPECTED, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) begin
            mode_next = M_IDLE;
          end
        end
        M_MINUS: begin
          if (is_digit(c)) begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, "-",
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            decimal_seen_next = 1'b0;
            mode_next = M_INT;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_UNEXPECTED, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            wr_en = (word_length < LW'(KEYWORD_CHARS));
            if (word_length <= LW'(KEYWORD_CHARS)) begin
              word_length_next = word_length + LW'(1);
            end
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_END, word_kind, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c) || c == ".") begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            if (c == ".") begin
              decimal_seen_next = 1'b1;
              mode_next = M_FRAC;
            end
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_END, KIND_INT, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
          end else if (c == ".") begin
            bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            mode_next = M_BADNUM;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_END, KIND_NUMBER, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_BADNUM: begin
          if (is_digit(c) || c == ".") begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_END, KIND_NUMBER, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            bundle.ev[n[1:0]] = make_ev(EV_END, KIND_STRING, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else if (c == 8'h0A) begin
            bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_UNTERMINATED, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            bundle.ev[n[1:0]] = make_ev(EV_ABANDON, KIND_STRING, ERR_EXTRA_POINT, 8'd0,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
            fresh = 1'b1;
          end else if (c == "\\") begin
            mode_next = M_ESC;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        start_offset, start_line, start_column);
            n = n + 3'd1;
          end
        end
        M_ESC: begin
          mode_next = M_STR;
          case (c)
            "n": bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, 8'h0A,
                                             start_offset, start_line, start_column);
            "r": bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, 8'h0D,
                                             start_offset, start_line, start_column);
            "t": bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, 8'h09,
                                             start_offset, start_line, start_column);
            "\"", "\\": bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                             start_offset, start_line, start_column);
            default: begin
              bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_ESCAPE, 8'd0,
                                          byte_offset, line_number, column_number);
              n = n + 3'd1;
              bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                          start_offset, start_line, start_column);
            end
          endcase
          n = n + 3'd1;
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode_next = M_IDLE;
        if (!is_space(c)) begin
          start_offset_next = byte_offset;
          start_line_next   = line_number;
          start_column_next = column_number;
          if (c == "/") begin
            mode_next = M_SLASH;
          end else if (c == "-") begin
            mode_next = M_MINUS;
          end else if (c == "\"") begin
            mode_next = M_STR;
          end else if (is_alpha(c) || c == "_") begin
            mode_next        = M_WORD;
            wr_en            = 1'b1;
            wr_idx           = '0;
            word_length_next = LW'(1);
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        byte_offset, line_number, column_number);
            n = n + 3'd1;
          end else if (is_digit(c)) begin
            mode_next         = M_INT;
            decimal_seen_next = 1'b0;
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        byte_offset, line_number, column_number);
            n = n + 3'd1;
          end else if (c == "=" || c == "{" || c == "}" || c == "[" || c == "]" ||
                       c == ",") begin
            bundle.ev[n[1:0]] = make_ev(EV_TEXT, KIND_IDENT, ERR_EXTRA_POINT, c,
                                        byte_offset, line_number, column_number);
            n = n + 3'd1;
            bundle.ev[n[1:0]] = make_ev(EV_END,
                                        (c == "=") ? KIND_ASSIGN :
                                        (c == "{") ? KIND_LBRACE :
                                        (c == "}") ? KIND_RBRACE :
                                        (c == "[") ? KIND_LBRACKET :
                                        (c == "]") ? KIND_RBRACKET : KIND_COMMA,
                                        ERR_EXTRA_POINT, 8'd0,
                                        byte_offset, line_number, column_number);
            n = n + 3'd1;
          end else begin
            bundle.ev[n[1:0]] = make_ev(EV_ERROR, KIND_IDENT, ERR_UNEXPECTED, 8'd0,
                                        byte_offset, line_number, column_number);
            n = n + 3'd1;
          end
        end
      end

      if (byte_offset < PosMax) begin
        byte_offset_next = byte_offset + PosW'(1);
      end
      if (c == 8'h0A) begin
        if (line_number < PosMax) begin
          line_number_next = line_number + PosW'(1);
        end
        column_number_next = PosW'(1);
      end else if (column_number < PosMax) begin
        column_number_next = column_number + PosW'(1);
      end
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      word_length   <= '0;
      decimal_seen  <= 1'b0;
      byte_offset   <= '0;
      line_number   <= PosW'(1);
      column_number <= PosW'(1);
      start_offset  <= '0;
      start_line    <= PosW'(1);
      start_column  <= PosW'(1);
      bytes_taken   <= '0;
    end else if (take) begin
      mode          <= mode_next;
      word_length   <= word_length_next;
      decimal_seen  <= decimal_seen_next;
      byte_offset   <= byte_offset_next;
      line_number   <= line_number_next;
      column_number <= column_number_next;
      start_offset  <= start_offset_next;
      start_line    <= start_line_next;
      start_column  <= start_column_next;
      bytes_taken   <= bytes_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !item.end_of_source && wr_en) begin
      word_store[wr_idx] <= c;
    end
  end

endmodule

// ===== sv/clt_queue.sv =====
module clt_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  clt_pkg::clt_bundle_t wr_data,
  input  logic                 rd,
  output clt_pkg::clt_bundle_t head,
  output clt_pkg::clt_qstat_t  stat
);
  import clt_pkg::*;

  clt_bundle_t    slots [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;
  logic             do_wr, do_rd;

  assign stat.full  = (count == (QPtrW+1)'(QueueDepth));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QPtrW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/clt_back.sv =====
module clt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  clt_pkg::clt_bundle_t head,
  input  clt_pkg::clt_qstat_t  qstat,
  input  logic                 pop,
  output logic                 q_rd,
  output logic                 empty,
  output clt_pkg::clt_result_t result
);
  import clt_pkg::*;

  logic [1:0] idx;
  logic       last;
  clt_event_t cur;

  assign cur   = head.ev[idx];
  assign last  = ({1'b0, idx} == head.count - 3'd1);
  assign empty = qstat.empty;
  assign q_rd  = pop && !empty && last;

  assign result.event_type      = cur.event_type;
  assign result.token_kind      = cur.token_kind;
  assign result.error_code      = cur.error_code;
  assign result.text_byte       = cur.text_byte;
  assign result.position_offset = cur.position_offset;
  assign result.position_line   = cur.position_line;
  assign result.position_column = cur.position_column;
  assign result.last_of_run     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !empty) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== sv/config_language_tokenizer.sv =====
// Streaming tokenizer: one source byte (or the end marker) is taken per cycle while full is
// low; each byte yields zero to three events, which leave one per cycle while pop is high
// through the result queue, with last_of_run on the final event of each byte. The lexer
// front runs a single state step per byte and hands its events, as one group, to a
// four-group queue; the back end walks each group one event per cycle in which pop is
// high, so a byte that makes several events holds the output until all are popped, and
// the queue absorbs bursts of them. A taken byte's events are registered into the queue.
`include "config_language_tokenizer_macros.svh"

module config_language_tokenizer #(
  parameter longint unsigned MAX_SOURCE_BYTES = 64'd16777216,
  parameter int              KEYWORD_CHARS    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  clt_pkg::clt_item_t   item,
  output logic                 empty,
  input  logic                 pop,
  output clt_pkg::clt_result_t result
);
  import clt_pkg::*;

  clt_bundle_t bundle, head;
  clt_qstat_t  qstat;
  logic        take, q_rd;

  assign full = qstat.full;
  assign take = push && !full;

  clt_front #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .KEYWORD_CHARS   (KEYWORD_CHARS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .bundle(bundle)
  );

  clt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take && bundle.count != 3'd0),
    .wr_data(bundle),
    .rd     (q_rd),
    .head   (head),
    .stat   (qstat)
  );

  clt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .q_rd  (q_rd),
    .empty (empty),
    .result(result)
  );

  `CLT_ASSERT_NOW(a_eof_last, !empty && result.token_kind == KIND_EOF, result.last_of_run, "end-of-file event not last of its beat")
  `CLT_ASSERT_NOW(a_error_kind, !empty && result.event_type == EV_ERROR, result.token_kind == KIND_IDENT, "error event carries a token kind")
  `CLT_ASSERT_NEXT(a_run_holds, pop && !empty && !result.last_of_run, !empty, "events of a beat lost")
  `CLT_ASSERT_NEXT(a_eof_queued, push && !full && item.end_of_source, !empty, "end marker produced no event")

endmodule
